/* hw/rtl/cdq_pkg.sv */
// cdq_pkg: shared types and codes for the circular deque.
// Holds the command and status codes, controller states and payload structs.
// No dependencies.
package cdq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] data_in;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic               last_result;
  } out_t;

endpackage

/* hw/rtl/circular_deque.sv */
// circular_deque: bounded double-ended queue of 32-bit words in a ring memory.
// Push, full and empty results appear in the cycle after acceptance; pop and list
// results pass through the memory read register, then the output register.
// Throughput: pushes one per cycle while results are taken; a pop holds off new
// commands until issued; list one word per cycle unless stalled. Uses cdq_pkg.
// Reset: control state, front index and count cleared; memory contents undefined.
module circular_deque #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cdq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdq_pkg::out_t out_o
);
  import cdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_P = AW'(CAPACITY - 1);

  logic signed [31:0] mem [CAPACITY];

  state_e             state_q, state_d;
  logic [AW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      walk_q, walk_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;
  logic signed [31:0] rd_data_q;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               out_free;
  logic               in_fire;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[AW-1:0];
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    walk_d      = walk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = ring_pos(front_q, count_q);
    rd_en       = 1'b0;
    rd_addr     = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_valid_d = 1'b1;
              out_d.data_out    = '0;
              out_d.last_result = 1'b1;
              if (count_q == CAP_C) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status = ST_OK;
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
                if (in_i.command == CMD_PUSH_FRONT) begin
                  front_d   = (front_q == '0) ? LAST_P : front_q - 1'b1;
                  mem_waddr = front_d;
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (count_q == '0) begin
                out_valid_d       = 1'b1;
                out_d.status      = ST_EMPTY;
                out_d.data_out    = '0;
                out_d.last_result = 1'b1;
              end else begin
                rd_en   = 1'b1;
                count_d = count_q - 1'b1;
                if (in_i.command == CMD_POP_FRONT) begin
                  rd_addr = front_q;
                  front_d = ring_pos(front_q, CW'(1));
                end else begin
                  rd_addr = ring_pos(front_q, count_q - 1'b1);
                end
                if (count_d == '0) begin
                  front_d = '0;
                end
                state_d = S_POP;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                out_valid_d       = 1'b1;
                out_d.status      = ST_EMPTY;
                out_d.data_out    = '0;
                out_d.last_result = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = front_q;
                walk_d  = '0;
                state_d = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = ST_OK;
          out_d.data_out    = rd_data_q;
          out_d.last_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = ST_OK;
          out_d.data_out    = rd_data_q;
          out_d.last_result = (walk_q == count_q - 1'b1);
          if (walk_q == count_q - 1'b1) begin
            state_d = S_IDLE;
          end else begin
            walk_d  = walk_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = ring_pos(front_q, walk_d);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Ring memory: pushes write, pops and list read; never both in one cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_i.data_in;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C) else $error("entry count above capacity");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> front_q == '0) else $error("front index not cleared when empty");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE && !rd_en)) else $error("memory write outside idle");

  a_pop_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> out_free) else $error("pop result has no free output slot");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |-> walk_q < count_q) else $error("list walk beyond stored entries");
`endif

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for circular_deque (push/pop at both ends, list).
// Directed table then random traffic under several idle/stall mixes, checked
// against an in-bench deque predictor. Depends on cdq_pkg and circular_deque.
`timescale 1ns / 100ps

module testbench;
  import cdq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int CLK_PERIOD   = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 64;
  localparam int PHASE_ITEMS  = 10;
  localparam int PRESS_ITEMS  = 8;
  localparam int NUM_ROWS     = 22;

  // unused command codes, must be dropped without a result
  localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

  localparam out_t RES_OK    = '{ST_OK, 32'sd0, 1'b1};
  localparam out_t RES_EMPTY = '{ST_EMPTY, 32'sd0, 1'b1};
  localparam out_t RES_FULL  = '{ST_FULL, 32'sd0, 1'b1};

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] word;
    int          reps;
    bit          typed;
    out_t        res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  // deque predictor state
  logic [31:0] ring_mem [CAPACITY];
  int unsigned head_idx;
  int unsigned word_cnt;

  out_t        pred_q[$];
  out_t        exp_q[$];
  bit          row_typed;
  out_t        row_res;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  bit          hold_taken;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  dir_row_t    dir_tab [NUM_ROWS];

  circular_deque #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("circular_deque verification failed");
      $finish;
    end
  end

  // fills pred_q with the results one command causes and advances the deque
  function automatic void predict_deque(in_t item);
    out_t        r;
    int unsigned slot;
    pred_q.delete();
    r = RES_OK;
    case (item.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (word_cnt == CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (item.command == CMD_PUSH_FRONT) begin
            head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
            slot     = head_idx;
          end else begin
            slot = (head_idx + word_cnt) % CAPACITY;
          end
          ring_mem[slot] = item.data_in;
          word_cnt++;
        end
        pred_q.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (word_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (item.command == CMD_POP_FRONT) begin
            slot     = head_idx;
            head_idx = (head_idx + 1) % CAPACITY;
          end else begin
            slot = (head_idx + word_cnt - 1) % CAPACITY;
          end
          word_cnt--;
          if (word_cnt == 0) head_idx = 0;
          r.data_out = ring_mem[slot];
        end
        pred_q.push_back(r);
      end
      CMD_LIST: begin
        if (word_cnt == 0) begin
          r.status = ST_EMPTY;
          pred_q.push_back(r);
        end else begin
          for (int unsigned k = 0; k < word_cnt; k++) begin
            r.data_out    = ring_mem[(head_idx + k) % CAPACITY];
            r.last_result = (k + 1 == word_cnt);
            pred_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_field(string fname, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0h/%0h/%0b",
                   $time, out_o.status, out_o.data_out, out_o.last_result);
          fail_cnt++;
        end else begin
          want = exp_q.pop_front();
          if (out_o.status !== want.status)
            report_field("status", 32'(want.status), 32'(out_o.status));
          if (out_o.data_out !== want.data_out)
            report_field("data_out", want.data_out, out_o.data_out);
          if (out_o.last_result !== want.last_result)
            report_field("last_result", 32'(want.last_result), 32'(out_o.last_result));
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_deque(in_i);
        if (row_typed) exp_q.push_back(row_res);
        else foreach (pred_q[k]) exp_q.push_back(pred_q[k]);
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_taken  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken  = 1'b1;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // called and left at a falling edge
  task automatic send_item(logic [2:0] cmd, logic [31:0] word, bit typed, out_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    in_i.command    = cmd;
    in_i.data_in    = word;
    row_typed       = typed;
    row_res         = res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    if ($urandom_range(3) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    if (r < 3 + push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (r < 88) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    return CMD_LIST;
  endfunction

  initial begin
    int unsigned idle_mix  [4];
    int unsigned stall_mix [4];
    int unsigned push_mix  [4];

    idle_mix  = '{0, 48, 0, 17};
    stall_mix = '{0, 0, 48, 17};
    push_mix  = '{50, 40, 45, 35};

    dir_tab = '{
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b1, RES_EMPTY},
      '{CMD_POP_BACK,   32'h0000_0000, 1,  1'b1, RES_EMPTY},
      '{CMD_LIST,       32'h0000_0000, 1,  1'b1, RES_EMPTY},
      '{CMD_RSVD_LO,    32'hFFFF_FFFF, 1,  1'b0, RES_OK},
      '{CMD_RSVD_MID,   32'h0000_0000, 1,  1'b0, RES_OK},
      '{CMD_RSVD_HI,    32'h5555_5555, 1,  1'b0, RES_OK},
      '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1, RES_OK},
      '{CMD_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, RES_OK},
      '{CMD_LIST,       32'h0000_0000, 1,  1'b0, RES_OK},
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{ST_OK, 32'sh8000_0000, 1'b1}},
      '{CMD_POP_BACK,   32'h0000_0000, 1,  1'b1, '{ST_OK, 32'sh7FFF_FFFF, 1'b1}},
      '{CMD_PUSH_FRONT, 32'hA5A5_0000, 16, 1'b1, RES_OK},
      '{CMD_PUSH_BACK,  32'h1234_5678, 1,  1'b1, RES_FULL},
      '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b1, RES_FULL},
      '{CMD_LIST,       32'h0000_0000, 1,  1'b0, RES_OK},
      '{CMD_POP_BACK,   32'h0000_0000, 8,  1'b0, RES_OK},
      '{CMD_PUSH_BACK,  32'hFFFF_FFF0, 8,  1'b0, RES_OK},
      '{CMD_LIST,       32'h0000_0000, 1,  1'b0, RES_OK},
      '{CMD_POP_FRONT,  32'h0000_0000, 16, 1'b0, RES_OK},
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b1, RES_EMPTY},
      '{CMD_PUSH_BACK,  32'h0000_0000, 1,  1'b1, RES_OK},
      '{CMD_POP_FRONT,  32'h0000_0000, 1,  1'b1, RES_OK}
    };

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    row_typed      = 1'b0;
    row_res        = RES_OK;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    fail_cnt       = 0;
    cycle_cnt      = 0;
    head_idx       = 0;
    word_cnt       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].reps; k++)
        send_item(dir_tab[i].cmd, dir_tab[i].word + k, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(pick_cmd(push_mix[p]), pick_word(), 1'b0, RES_OK);
    end

    // long result hold-off while pushes keep coming: fills the output path
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (int k = 0; k < PRESS_ITEMS; k++)
      send_item($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word(), 1'b0, RES_OK);
    for (int k = 0; k < PHASE_ITEMS; k++)
      send_item(pick_cmd(20), pick_word(), 1'b0, RES_OK);

    in_valid_i = 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("circular_deque verification clean");
    end else begin
      $display("circular_deque verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cdq_pkg.sv
hw/rtl/circular_deque.sv
tb/testbench.sv
